// File: hw/rtl/assert_macros.svh
// assertion macros for the layer assigner rtl
// no dependencies; included by files that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_PROP(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("property check failed");

// condition must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");

`endif

// File: hw/rtl/gala_pkg.sv
// shared types, constants and controller interface for the layer assigner
// no dependencies
package gala_pkg;

	localparam int unsigned QUBIT_W = 10;
	localparam int unsigned INDEX_W = 16;
	localparam int unsigned COUNT_W = 17;

	localparam int unsigned QUBIT_CNT_DEF = 1024;
	localparam longint unsigned MAX_SLICES_DEF = 64'd65536;

	// reciprocal scale used to reduce qubit indexes
	localparam int unsigned RECIP_SHIFT = 20;

	typedef struct packed {
		logic [QUBIT_W-1:0] first_qubit;
		logic [QUBIT_W-1:0] second_qubit;
		logic               is_two_qubit;
	} gate_t;

	typedef struct packed {
		logic               placed;
		logic [INDEX_W-1:0] slice_index;
		logic [COUNT_W-1:0] slice_count;
	} result_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_CALC,
		ST_WRITE_B
	} gala_state_t;

	typedef struct packed {
		logic clear_en;
		logic load_en;
		logic skip_emit;
		logic read_en;
		logic calc_en;
		logic wr_b_en;
		logic emit_en;
	} gala_cmd_t;

	typedef struct packed {
		logic clear_done;
		logic skip;
		logic two;
	} gala_status_t;

endpackage

// File: hw/rtl/gala_ram.sv
// generic ram, one write port, two registered read ports
// no dependencies
module gala_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

// File: hw/rtl/gala_ctrl.sv
// controller state machine: clearing pass, accept, read, compute, second write
// depends on gala_pkg
module gala_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  gala_pkg::gala_status_t status,
	output gala_pkg::gala_cmd_t    cmd,
	output logic                  busy
);

	import gala_pkg::*;

	gala_state_t state_q;
	gala_state_t state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (status.clear_done) begin
					state_n = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start && !status.skip) begin
					state_n = ST_READ;
				end
			end
			ST_READ: begin
				state_n = ST_CALC;
			end
			ST_CALC: begin
				state_n = status.two ? ST_WRITE_B : ST_IDLE;
			end
			ST_WRITE_B: begin
				state_n = ST_IDLE;
			end
			default: begin
				state_n = ST_CLEAR;
			end
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear_en = 1'b1;
			end
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.skip_emit = status.skip;
					cmd.load_en   = !status.skip;
				end
			end
			ST_READ: begin
				cmd.read_en = 1'b1;
			end
			ST_CALC: begin
				cmd.calc_en = 1'b1;
				cmd.emit_en = !status.two;
			end
			ST_WRITE_B: begin
				cmd.wr_b_en = 1'b1;
				cmd.emit_en = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

endmodule

// File: hw/rtl/gala_dp.sv
// datapath: index reduction, per-qubit table, slice compute, slice count, result
// depends on gala_pkg and gala_ram
module gala_dp #(
	parameter int unsigned     QUBIT_CNT  = gala_pkg::QUBIT_CNT_DEF,
	parameter longint unsigned MAX_SLICES = gala_pkg::MAX_SLICES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  gala_pkg::gala_cmd_t    cmd,
	output gala_pkg::gala_status_t status,
	input  gala_pkg::gate_t        gate,
	input  logic                  cfg_we,
	input  logic                  cfg_wdata,
	output logic                  done,
	output gala_pkg::result_t      result
);

	import gala_pkg::*;

	localparam int unsigned ADDR_W  = $clog2(QUBIT_CNT);
	localparam int unsigned SLICE_W = $clog2(MAX_SLICES);
	localparam int unsigned CNT_W   = $clog2(MAX_SLICES + 64'd1);
	localparam int unsigned RECIP   = (32'd1 << RECIP_SHIFT) / QUBIT_CNT;
	localparam logic [SLICE_W-1:0] TOP_SLICE = SLICE_W'(MAX_SLICES - 64'd1);

	logic                  two_only_q;
	logic [QUBIT_W-1:0]    qa_q;
	logic [QUBIT_W-1:0]    qb_q;
	logic [QUBIT_W-1:0]    qda_q;
	logic [QUBIT_W-1:0]    qdb_q;
	logic                  two_q;
	logic [ADDR_W-1:0]     addr_a;
	logic [ADDR_W-1:0]     addr_b;
	logic [ADDR_W-1:0]     addr_a_q;
	logic [ADDR_W-1:0]     addr_b_q;
	logic [ADDR_W-1:0]     clr_cnt_q;
	logic [SLICE_W-1:0]    slot_q;
	logic [CNT_W-1:0]      count_q;
	logic                  we;
	logic [ADDR_W-1:0]     waddr;
	logic [SLICE_W:0]      wdata;
	logic [SLICE_W:0]      rdata_a;
	logic [SLICE_W:0]      rdata_b;
	logic                  seen_a;
	logic                  seen_b;
	logic                  use_b;
	logic                  any_seen;
	logic [SLICE_W-1:0]    latest;
	logic [SLICE_W-1:0]    slot;
	logic [CNT_W-1:0]      slot_plus;
	logic [CNT_W-1:0]      count_n;

	// index modulo qubit count, from a quotient estimate that is low by at most one
	function automatic logic [ADDR_W-1:0] reduce(
		input logic [QUBIT_W-1:0] q,
		input logic [QUBIT_W-1:0] qd
	);
		logic [31:0] r;
		r = 32'(q) - 32'(qd) * 32'(QUBIT_CNT);
		if (r >= 32'(QUBIT_CNT)) begin
			r = r - 32'(QUBIT_CNT);
		end
		return ADDR_W'(r);
	endfunction

	function automatic logic [QUBIT_W-1:0] quot_est(input logic [QUBIT_W-1:0] q);
		logic [31:0] p;
		p = 32'(q) * 32'(RECIP);
		return QUBIT_W'(p >> RECIP_SHIFT);
	endfunction

	assign status.skip       = two_only_q && !gate.is_two_qubit;
	assign status.two        = two_q;
	assign status.clear_done = (clr_cnt_q == ADDR_W'(QUBIT_CNT - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			two_only_q <= 1'b0;
		end else if (cfg_we) begin
			two_only_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clear_en && !status.clear_done) begin
			clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_en) begin
			qa_q  <= gate.first_qubit;
			qb_q  <= gate.second_qubit;
			qda_q <= quot_est(gate.first_qubit);
			qdb_q <= quot_est(gate.second_qubit);
			two_q <= gate.is_two_qubit;
		end
		if (cmd.read_en) begin
			addr_a_q <= addr_a;
			addr_b_q <= addr_b;
		end
		if (cmd.calc_en) begin
			slot_q <= slot;
		end
	end

	assign addr_a = reduce(qa_q, qda_q);
	assign addr_b = reduce(qb_q, qdb_q);

	always_comb begin
		we = cmd.clear_en || cmd.calc_en || cmd.wr_b_en;
		priority if (cmd.clear_en) begin
			waddr = clr_cnt_q;
			wdata = '0;
		end else if (cmd.calc_en) begin
			waddr = addr_a_q;
			wdata = {1'b1, slot};
		end else begin
			waddr = addr_b_q;
			wdata = {1'b1, slot_q};
		end
	end

	gala_ram #(
		.WIDTH (SLICE_W + 1),
		.DEPTH (QUBIT_CNT)
	) u_table (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr_a (addr_a),
		.raddr_b (addr_b),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	// latest slice over the gate's qubits, then one past it with saturation
	always_comb begin
		seen_a   = rdata_a[SLICE_W];
		seen_b   = rdata_b[SLICE_W];
		use_b    = two_q && seen_b;
		any_seen = seen_a || use_b;
		if (use_b && (!seen_a || (rdata_b[SLICE_W-1:0] > rdata_a[SLICE_W-1:0]))) begin
			latest = rdata_b[SLICE_W-1:0];
		end else begin
			latest = rdata_a[SLICE_W-1:0];
		end
		if (!any_seen) begin
			slot = '0;
		end else if (latest >= TOP_SLICE) begin
			slot = TOP_SLICE;
		end else begin
			slot = latest + SLICE_W'(1);
		end
		slot_plus = CNT_W'(slot) + CNT_W'(1);
		count_n   = (slot_plus > count_q) ? slot_plus : count_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CNT_W'(1);
			done    <= 1'b0;
		end else begin
			if (cmd.calc_en) begin
				count_q <= count_n;
			end
			done <= cmd.emit_en || cmd.skip_emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.skip_emit) begin
			result.placed      <= 1'b0;
			result.slice_index <= '0;
			result.slice_count <= COUNT_W'(count_q);
		end else if (cmd.calc_en) begin
			result.placed      <= 1'b1;
			result.slice_index <= INDEX_W'(slot);
			result.slice_count <= COUNT_W'(count_n);
		end
	end

endmodule

// File: hw/rtl/gate_asap_layer_assigner_core.sv
// top level of the asap layer assigner: controller plus datapath
// depends on gala_pkg, gala_ctrl, gala_dp, gala_ram and assert_macros.svh
//
//  port group          direction  handshake
//  gate                in         start, accepted when start && !busy
//  result              out        done, one-cycle strobe, always taken
//  cfg_wdata           in         cfg_we, written at the edge
//
// a skipped gate is answered from idle; others are read, then computed; a
// two-qubit gate writes its entries in turn: the table has one write port.
// after reset all table entries are cleared with busy high. the result comes
// the cycle after the last write; the receiver cannot stall.
`include "assert_macros.svh"

module gate_asap_layer_assigner_core #(
	parameter int unsigned     QUBIT_CNT  = gala_pkg::QUBIT_CNT_DEF,
	parameter longint unsigned MAX_SLICES = gala_pkg::MAX_SLICES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  gala_pkg::gate_t   gate,
	input  logic              cfg_we,
	input  logic              cfg_wdata,
	output logic              done,
	output gala_pkg::result_t result
);

	import gala_pkg::*;

	gala_cmd_t    cmd;
	gala_status_t status;
	logic         accept;

	assign accept = start && !busy;

	gala_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	gala_dp #(
		.QUBIT_CNT  (QUBIT_CNT),
		.MAX_SLICES (MAX_SLICES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.gate      (gate),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.done      (done),
		.result    (result)
	);

	`ASSERT_PROP(a_skip_result, clk, arst_n, (accept && status.skip) |=> (done && !result.placed))
	`ASSERT_PROP(a_gate_busy, clk, arst_n, (accept && !status.skip) |=> (busy && !done))
	`ASSERT_NEVER(a_skip_index, clk, arst_n, done && !result.placed && (result.slice_index != '0))

endmodule

// File: tb/sv/tb_gate_asap_layer_assigner_core.sv
// self-checking testbench for gate_asap_layer_assigner_core: directed gate table, then
// random gate streams under both mode settings; depends on gala_pkg and the core rtl
`timescale 1ns / 100ps

module tb_gate_asap_layer_assigner_core;
	import gala_pkg::*;

	localparam int unsigned QUIET_LIMIT = 5000;
	localparam int unsigned NUM_DIR = 23;
	localparam longint unsigned SLICE_TOP = MAX_SLICES_DEF - 1;

	typedef struct packed {
		logic               mode;
		logic [QUBIT_W-1:0] first;
		logic [QUBIT_W-1:0] second;
		logic               two;
		logic               typed;
		logic               want_placed;
		logic [INDEX_W-1:0] want_slot;
		logic [COUNT_W-1:0] want_count;
	} dir_row_t;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    start = 1'b0;
	logic    busy;
	gate_t   gate = '0;
	logic    cfg_we = 1'b0;
	logic    cfg_wdata = 1'b0;
	logic    done;
	result_t result;

	// shadow of the slicing state
	bit              qubit_used [QUBIT_CNT_DEF];
	longint unsigned last_slice [QUBIT_CNT_DEF];
	longint unsigned slice_total = 1;
	bit              skip_single = 1'b0;

	result_t     due_results [$];
	int unsigned mismatch_count = 0;
	int unsigned quiet_cycles = 0;
	int unsigned sender_idle_pct = 0;

	dir_row_t dir_rows [NUM_DIR] = '{
		'{1'b0, 10'd0,    10'd0,    1'b0, 1'b1, 1'b1, 16'd0, 17'd1},
		'{1'b0, 10'd1023, 10'd0,    1'b0, 1'b1, 1'b1, 16'd0, 17'd1},
		'{1'b0, 10'd0,    10'd1023, 1'b1, 1'b1, 1'b1, 16'd1, 17'd2},
		'{1'b0, 10'd5,    10'd5,    1'b1, 1'b1, 1'b1, 16'd0, 17'd2},
		'{1'b0, 10'd5,    10'd5,    1'b1, 1'b1, 1'b1, 16'd1, 17'd2},
		'{1'b0, 10'd5,    10'd0,    1'b0, 1'b1, 1'b1, 16'd2, 17'd3},
		'{1'b0, 10'd1023, 10'd682,  1'b1, 1'b1, 1'b1, 16'd2, 17'd3},
		'{1'b0, 10'd341,  10'd1023, 1'b0, 1'b1, 1'b1, 16'd0, 17'd3},
		'{1'b1, 10'd0,    10'd0,    1'b0, 1'b1, 1'b0, 16'd0, 17'd3},
		'{1'b1, 10'd1023, 10'd1023, 1'b0, 1'b1, 1'b0, 16'd0, 17'd3},
		'{1'b1, 10'd0,    10'd5,    1'b1, 1'b1, 1'b1, 16'd3, 17'd4},
		'{1'b1, 10'd341,  10'd682,  1'b1, 1'b1, 1'b1, 16'd3, 17'd4},
		'{1'b1, 10'd7,    10'd7,    1'b1, 1'b1, 1'b1, 16'd0, 17'd4},
		'{1'b1, 10'd5,    10'd0,    1'b0, 1'b1, 1'b0, 16'd0, 17'd4},
		'{1'b0, 10'd5,    10'd0,    1'b0, 1'b1, 1'b1, 16'd4, 17'd5},
		'{1'b0, 10'd0,    10'd5,    1'b1, 1'b1, 1'b1, 16'd5, 17'd6},
		'{1'b0, 10'd1023, 10'd0,    1'b1, 1'b1, 1'b1, 16'd6, 17'd7},
		'{1'b0, 10'd0,    10'd1023, 1'b1, 1'b1, 1'b1, 16'd7, 17'd8},
		'{1'b0, 10'd5,    10'd7,    1'b1, 1'b1, 1'b1, 16'd6, 17'd8},
		'{1'b0, 10'd682,  10'd341,  1'b1, 1'b0, 1'b0, 16'd0, 17'd0},
		'{1'b1, 10'd341,  10'd682,  1'b0, 1'b0, 1'b0, 16'd0, 17'd0},
		'{1'b1, 10'd682,  10'd341,  1'b1, 1'b0, 1'b0, 16'd0, 17'd0},
		'{1'b0, 10'd1023, 10'd1023, 1'b1, 1'b0, 1'b0, 16'd0, 17'd0}
	};

	gate_asap_layer_assigner_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.gate     (gate),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.done     (done),
		.result   (result)
	);

	always #5 clk = ~clk;

	function automatic result_t place_gate(gate_t g);
		int unsigned     qa;
		int unsigned     qb;
		longint unsigned latest;
		longint unsigned slot;
		bit              any;
		result_t         r;
		qa = g.first_qubit % QUBIT_CNT_DEF;
		qb = g.second_qubit % QUBIT_CNT_DEF;
		r = '0;
		if (skip_single && !g.is_two_qubit) begin
			r.slice_count = COUNT_W'(slice_total);
			return r;
		end
		any = 1'b0;
		latest = 0;
		if (qubit_used[qa]) begin
			any = 1'b1;
			latest = last_slice[qa];
		end
		if (g.is_two_qubit && qubit_used[qb]) begin
			if (!any || last_slice[qb] > latest)
				latest = last_slice[qb];
			any = 1'b1;
		end
		slot = 0;
		if (any)
			slot = (latest >= SLICE_TOP) ? SLICE_TOP : latest + 1;
		qubit_used[qa] = 1'b1;
		last_slice[qa] = slot;
		if (g.is_two_qubit) begin
			qubit_used[qb] = 1'b1;
			last_slice[qb] = slot;
		end
		if (slot + 1 > slice_total)
			slice_total = slot + 1;
		if (slice_total > MAX_SLICES_DEF)
			slice_total = MAX_SLICES_DEF;
		r.placed = 1'b1;
		r.slice_index = INDEX_W'(slot);
		r.slice_count = COUNT_W'(slice_total);
		return r;
	endfunction

	// mostly a narrow window of qubits so that gates pile up on each other
	function automatic gate_t rand_gate(logic [QUBIT_W-1:0] pool);
		gate_t g;
		g.is_two_qubit = 1'($urandom_range(1));
		if ($urandom_range(99) < 70) begin
			g.first_qubit = QUBIT_W'(pool + $urandom_range(15));
			g.second_qubit = QUBIT_W'(pool + $urandom_range(15));
		end else begin
			g.first_qubit = QUBIT_W'($urandom_range(1023));
			g.second_qubit = QUBIT_W'($urandom_range(1023));
		end
		if ($urandom_range(19) == 0)
			g.second_qubit = g.first_qubit;
		return g;
	endfunction

	task automatic push_gate(input gate_t g, input bit typed, input result_t want);
		result_t r;
		while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		gate <= g;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		r = place_gate(g);
		due_results.push_back(typed ? want : r);
	endtask

	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (due_results.size() != 0 || busy)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_mode(input bit m);
		settle();
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we <= 1'b0;
		skip_single = m;
	endtask

	task automatic check_field(input string name, input logic [COUNT_W-1:0] want,
			input logic [COUNT_W-1:0] got);
		if (got !== want) begin
			mismatch_count++;
			$error("%s: expected %0d, got %0d", name, want, got);
		end
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n && done) begin
			if (due_results.size() == 0) begin
				mismatch_count++;
				$error("result with no item pending");
			end else begin
				want = due_results.pop_front();
				check_field("placed", COUNT_W'(want.placed), COUNT_W'(result.placed));
				check_field("slice_index", COUNT_W'(want.slice_index),
					COUNT_W'(result.slice_index));
				check_field("slice_count", want.slice_count, result.slice_count);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	initial begin
		dir_row_t row;
		gate_t    g;
		result_t  want;
		logic [QUBIT_W-1:0] pool;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		// waits out the table clearing pass
		set_mode(1'b0);

		sender_idle_pct = 27;
		foreach (dir_rows[i]) begin
			row = dir_rows[i];
			if (row.mode != skip_single)
				set_mode(row.mode);
			g.first_qubit = row.first;
			g.second_qubit = row.second;
			g.is_two_qubit = row.two;
			want.placed = row.want_placed;
			want.slice_index = row.want_slot;
			want.slice_count = row.want_count;
			push_gate(g, row.typed, want);
		end

		for (int b = 0; b < 6; b++) begin
			sender_idle_pct = (b < 2) ? 27 : (b < 4) ? 81 : 0;
			set_mode(b % 2 == 0);
			pool = QUBIT_W'($urandom_range(1023));
			for (int n = 0; n < 92; n++) begin
				if (b == 0 && n == 46)
					settle();
				push_gate(rand_gate(pool), 1'b0, '0);
			end
		end

		settle();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/gala_pkg.sv
hw/rtl/gala_ram.sv
hw/rtl/gala_ctrl.sv
hw/rtl/gala_dp.sv
hw/rtl/gate_asap_layer_assigner_core.sv
tb/sv/tb_gate_asap_layer_assigner_core.sv
